FILE: rtl/gscbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscbr_pkg
// Shared types and constants of the grid shift cipher with group reversal.
// ----------------------------------------------------------------------------
package gscbr_pkg;

    // Depth of the group stack and the widths that follow from it.
    localparam int MaxGroup = 64;
    localparam int AddrW    = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;
    localparam int CntW     = $clog2(MaxGroup + 1);

    // Fixed field widths.
    localparam int CharW    = 8;
    localparam int ShiftW   = 3;
    localparam int LenW     = 7;
    localparam int CmpW     = (CntW > LenW) ? CntW : LenW;

    // Register indexes on the configuration port.
    localparam logic [1:0] RegShiftRow = 2'd0;
    localparam logic [1:0] RegShiftCol = 2'd1;
    localparam logic [1:0] RegGroupLen = 2'd2;

    // One stack entry: the flag above the character.
    typedef struct packed {
        logic             not_in_grid;
        logic [CharW-1:0] ch;
    } t_entry;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_FLUSH = 1'b1
    } t_state;

endpackage

FILE: rtl/gscbr_subst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscbr_subst
// Grid substitution: locates a character in the 6x6 grid and replaces it.
// ----------------------------------------------------------------------------
module gscbr_subst (
    input  logic [gscbr_pkg::CharW-1:0]  i_char,
    input  logic [gscbr_pkg::ShiftW-1:0] i_shift_row,
    input  logic [gscbr_pkg::ShiftW-1:0] i_shift_col,
    output gscbr_pkg::t_entry            o_entry
);

    logic       in_grid;
    logic [5:0] k;
    logic [2:0] row;
    logic [2:0] col;
    logic [2:0] srm;
    logic [2:0] scm;
    logic [3:0] nr;
    logic [3:0] nc;
    logic [5:0] nk;
    logic [5:0] row6;
    logic [5:0] nr6;

    // Shifts are taken modulo 6.
    assign srm = (i_shift_row >= 3'd6) ? i_shift_row - 3'd6 : i_shift_row;
    assign scm = (i_shift_col >= 3'd6) ? i_shift_col - 3'd6 : i_shift_col;

    always_comb begin
        in_grid = 1'b1;
        k       = 6'd0;
        if (i_char >= 8'd65 && i_char <= 8'd90) begin
            k = 6'(i_char - 8'd65);
        end else if (i_char >= 8'd49 && i_char <= 8'd57) begin
            k = 6'(i_char - 8'd49 + 8'd26);
        end else if (i_char == 8'd32) begin
            k = 6'd35;
        end else begin
            in_grid = 1'b0;
        end
    end

    // Row by threshold compares, column as the remainder.
    always_comb begin
        if (k >= 6'd30)      row = 3'd5;
        else if (k >= 6'd24) row = 3'd4;
        else if (k >= 6'd18) row = 3'd3;
        else if (k >= 6'd12) row = 3'd2;
        else if (k >= 6'd6)  row = 3'd1;
        else                 row = 3'd0;
    end

    assign row6 = ({3'b000, row} << 2) + ({3'b000, row} << 1);
    assign col  = 3'(k - row6);

    assign nr  = (row >= srm) ? {1'b0, row} - {1'b0, srm} : {1'b0, row} + 4'd6 - {1'b0, srm};
    assign nc  = (col >= scm) ? {1'b0, col} - {1'b0, scm} : {1'b0, col} + 4'd6 - {1'b0, scm};
    assign nr6 = ({2'b00, nr} << 2) + ({2'b00, nr} << 1);
    assign nk  = nr6 + {2'b00, nc};

    always_comb begin
        o_entry.not_in_grid = ~in_grid;
        if (!in_grid)          o_entry.ch = 8'd0;
        else if (nk < 6'd26)   o_entry.ch = 8'd65 + {2'b00, nk};
        else if (nk < 6'd35)   o_entry.ch = 8'd23 + {2'b00, nk};
        else                   o_entry.ch = 8'd32;
    end

endmodule

FILE: rtl/grid_shift_cipher_block_reverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_shift_cipher_block_reverse_core
// Substitutes message characters through a shifted 6x6 grid and emits them in
// reversed groups, using a single-port stack memory.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                       Carries
// s_axis    in         tvalid/tready/tdata/tlast     char_in, tlast = msg_end
// m_axis    out        tvalid/tready/tdata/tuser/    char_out, tuser = {group_last,
//                      tlast                         not_in_grid}, tlast = msg_last
// apb       in         psel/penable/pwrite/paddr/    shift_row @0, shift_col @4,
//                      pwdata/prdata/pready          group_len @8
//
// A request is pushed onto the stack in the cycle it is accepted. When the push
// completes a group (or carries msg_end) the block flushes: the stack memory is
// read once per cycle, top first, unless an output stall holds the reads.
// Input requests are refused from the completing push until the last read of
// the flush is issued. Output stalls hold the read pipeline; the output
// register keeps the next request's pushes apart from a waiting result.
// Reset is synchronous and active low; it clears the count, the state, the
// configuration registers and the valid flags, while the stack memory keeps
// its contents, which are never read before being written.
// ----------------------------------------------------------------------------
module grid_shift_cipher_block_reverse_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // msg_end
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_out
    output logic [1:0]  m_axis_tuser,   // [0] not_in_grid, [1] group_last
    output logic        m_axis_tlast,   // msg_last
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AddrW = gscbr_pkg::AddrW;
    localparam int CntW  = gscbr_pkg::CntW;
    localparam int CmpW  = gscbr_pkg::CmpW;

    // Configuration registers.
    logic [gscbr_pkg::ShiftW-1:0] r_shift_row;
    logic [gscbr_pkg::ShiftW-1:0] r_shift_col;
    logic [gscbr_pkg::LenW-1:0]   r_group_len;
    logic                         cfg_wr;

    // Control.
    gscbr_pkg::t_state r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_end, n_end;
    logic              push;
    logic              flush_now;
    logic              rd_issue;
    logic              load;
    logic [CntW-1:0]   limit;
    logic [CntW-1:0]   cnt_inc;

    // Stack memory and its registered read side.
    gscbr_pkg::t_entry mem [gscbr_pkg::MaxGroup];
    gscbr_pkg::t_entry sub_entry;
    gscbr_pkg::t_entry r_rd_data;
    logic              r_rd_vld;
    logic              r_rd_glast;
    logic              r_rd_mlast;
    logic [AddrW-1:0]  rd_addr;

    // Output register.
    logic              r_out_vld;
    gscbr_pkg::t_entry r_out_data;
    logic              r_out_glast;
    logic              r_out_mlast;

    // ------------------------------------------------------------------
    // Configuration port: writes land on the access cycle, reads are
    // returned straight from the registers.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_row <= '0;
            r_shift_col <= '0;
            r_group_len <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gscbr_pkg::RegShiftRow: r_shift_row <= pwdata[gscbr_pkg::ShiftW-1:0];
                gscbr_pkg::RegShiftCol: r_shift_col <= pwdata[gscbr_pkg::ShiftW-1:0];
                gscbr_pkg::RegGroupLen: r_group_len <= pwdata[gscbr_pkg::LenW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gscbr_pkg::RegShiftRow: prdata = {{(32-gscbr_pkg::ShiftW){1'b0}}, r_shift_row};
            gscbr_pkg::RegShiftCol: prdata = {{(32-gscbr_pkg::ShiftW){1'b0}}, r_shift_col};
            gscbr_pkg::RegGroupLen: prdata = {{(32-gscbr_pkg::LenW){1'b0}}, r_group_len};
            default:                prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Substitution of the incoming character.
    // ------------------------------------------------------------------
    gscbr_subst u_subst (
        .i_char      (s_axis_tdata),
        .i_shift_row (r_shift_row),
        .i_shift_col (r_shift_col),
        .o_entry     (sub_entry)
    );

    // A group length of zero, or one beyond the stack depth, means the full
    // stack depth.
    always_comb begin
        if (r_group_len == '0 ||
            CmpW'(r_group_len) > CmpW'(gscbr_pkg::MaxGroup)) begin
            limit = CntW'(gscbr_pkg::MaxGroup);
        end else begin
            limit = CntW'(r_group_len);
        end
    end

    assign cnt_inc   = r_cnt + CntW'(1);
    assign flush_now = (cnt_inc >= limit) || s_axis_tlast;
    assign push      = s_axis_tvalid & s_axis_tready;

    // The read data register is free when empty or when it moves to the
    // output register in this cycle.
    assign load     = r_rd_vld & (~r_out_vld | m_axis_tready);
    assign rd_addr  = AddrW'(r_cnt - CntW'(1));

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            gscbr_pkg::ST_IDLE: begin
                if (push && flush_now) n_state = gscbr_pkg::ST_FLUSH;
            end
            gscbr_pkg::ST_FLUSH: begin
                if (rd_issue && r_cnt == CntW'(1)) n_state = gscbr_pkg::ST_IDLE;
            end
            default: n_state = gscbr_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        rd_issue      = 1'b0;
        case (r_state)
            gscbr_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            gscbr_pkg::ST_FLUSH: rd_issue      = ~r_rd_vld | load;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_end = r_end;
        if (push) begin
            n_cnt = cnt_inc;
            n_end = s_axis_tlast;
        end else if (rd_issue) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gscbr_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_end   <= n_end;
        end
    end

    // ------------------------------------------------------------------
    // Stack memory: one write port for pushes, one registered read for pops.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[AddrW'(r_cnt)] <= sub_entry;
        end
        if (rd_issue) begin
            r_rd_data  <= mem[rd_addr];
            r_rd_glast <= (r_cnt == CntW'(1));
            r_rd_mlast <= (r_cnt == CntW'(1)) & r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (rd_issue) begin
            r_rd_vld <= 1'b1;
        end else if (load) begin
            r_rd_vld <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data  <= r_rd_data;
            r_out_glast <= r_rd_glast;
            r_out_mlast <= r_rd_mlast;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data.ch;
    assign m_axis_tuser  = {r_out_glast, r_out_data.not_in_grid};
    assign m_axis_tlast  = r_out_mlast;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(gscbr_pkg::MaxGroup))
        else $error("stack count beyond stack depth");

    a_no_push_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gscbr_pkg::ST_FLUSH |-> !push)
        else $error("push accepted during a flush");

    a_flush_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |=> r_cnt == $past(r_cnt) - CntW'(1))
        else $error("flush read without count decrement");

    a_msg_last_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("message end not on a group end");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gscbr_pkg::ST_FLUSH |-> r_cnt != '0)
        else $error("flush with an empty stack");

endmodule

FILE: dv/tb_grid_shift_cipher_block_reverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_shift_cipher_block_reverse_core
// Self-checking bench for the grid shift cipher with reversed groups. A shadow
// copy of the grid substitution and of the group stack predicts every output
// character. Each output character is checked against the oldest prediction.
// Short directed messages come first. Randomised messages follow, under
// varied shift and group settings, with random idling on both streams, one
// long output stall and a closing stretch at full rate.
// ----------------------------------------------------------------------------
module tb_grid_shift_cipher_block_reverse_core;

    localparam int ClkPeriod      = 20;
    localparam int ResetCycles    = 5;
    localparam int DrainCycles    = 8;      // settle time after the last result
    localparam int LongHoldCycles = 400;    // long output stall
    localparam int RandomItems    = 24;     // characters sent in small random messages
    localparam longint TimeoutCycles = 200000;

    // Grid layout: letters, then digits 1..9, then space, 6 by 6.
    localparam logic [7:0] ChA     = 8'h41;
    localparam logic [7:0] ChZ     = 8'h5A;
    localparam logic [7:0] Ch1     = 8'h31;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam int GridDim    = 6;
    localparam int GridCells  = GridDim * GridDim;
    localparam int NumLetters = 26;
    localparam int NumDigits  = 9;

    // One predicted output character.
    typedef struct packed {
        logic [gscbr_pkg::CharW-1:0] ch;
        logic                        not_in_grid;
        logic                        group_last;
        logic                        msg_last;
    } t_cipher_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] char_in
    logic        s_axis_tlast;      // msg_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;      // [7:0] char_out
    logic [1:0]  m_axis_tuser;      // [0] not_in_grid, [1] group_last
    logic        m_axis_tlast;      // msg_last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the configuration registers and of the group stack.
    logic [gscbr_pkg::ShiftW-1:0] shift_row_q;
    logic [gscbr_pkg::ShiftW-1:0] shift_col_q;
    logic [gscbr_pkg::LenW-1:0]   group_len_q;
    gscbr_pkg::t_entry            shadow_stack [gscbr_pkg::MaxGroup];
    int                           shadow_depth;

    // Output characters predicted but not yet seen, oldest first.
    t_cipher_out pending_chars [$];

    int fail_count;
    bit idle_on;        // random gaps on both streams
    bit hold_request;   // asks the output side for one long stall

    grid_shift_cipher_block_reverse_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // The clock starts low, so its first edge is a rising one.
    initial i_clk = 1'b0;
    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow model of the cipher
    // ------------------------------------------------------------------------

    // The character held at grid cell k (0..35), counted row by row.
    function automatic logic [7:0] grid_char(input int k);
        if (k < NumLetters) begin
            return 8'(ChA + k);
        end
        if (k < NumLetters + NumDigits) begin
            return 8'(Ch1 + k - NumLetters);
        end
        return ChSpace;
    endfunction

    // Moves a character back by the row and column shifts, both taken
    // modulo 6, so that register values 6 and 7 wrap round to 0 and 1.
    function automatic gscbr_pkg::t_entry encipher(input logic [7:0] c);
        int                k;
        int                r;
        int                q;
        gscbr_pkg::t_entry e;
        e = '0;
        if (c >= ChA && c <= ChZ) begin
            k = c - ChA;
        end else if (c >= Ch1 && c <= Ch9) begin
            k = c - Ch1 + NumLetters;
        end else if (c == ChSpace) begin
            k = GridCells - 1;
        end else begin
            k = GridCells;
        end
        if (k == GridCells) begin
            // Off the grid: a zero character with the flag raised.
            e.not_in_grid = 1'b1;
            return e;
        end
        r = (k / GridDim + GridDim - int'(shift_row_q) % GridDim) % GridDim;
        q = (k % GridDim + GridDim - int'(shift_col_q) % GridDim) % GridDim;
        e.ch = grid_char(r * GridDim + q);
        return e;
    endfunction

    // Pushes one accepted request and, when the group is complete or the
    // message ends, queues the whole stack top first.
    task automatic push_and_flush(input logic [7:0] c, input logic msg_end);
        int          limit;
        t_cipher_out want;
        // A group length of zero, or one beyond the stack, means the stack depth.
        limit = (group_len_q == 0 || group_len_q > gscbr_pkg::MaxGroup) ?
                gscbr_pkg::MaxGroup : group_len_q;
        shadow_stack[shadow_depth] = encipher(c);
        shadow_depth++;
        if (shadow_depth >= limit || msg_end) begin
            while (shadow_depth > 0) begin
                shadow_depth--;
                want.ch          = shadow_stack[shadow_depth].ch;
                want.not_in_grid = shadow_stack[shadow_depth].not_in_grid;
                want.group_last  = (shadow_depth == 0);
                want.msg_last    = (shadow_depth == 0) && msg_end;
                pending_chars.push_back(want);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // One APB transfer: a setup phase, then the access phase held until pready.
    // It finishes with psel low so that back-to-back transfers never
    // drop and raise psel within the same time step.
    task automatic apb_access(input bit wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] reg_mask(input logic [1:0] idx);
        return (idx == gscbr_pkg::RegGroupLen) ? 32'h7F : 32'h7;
    endfunction

    // Reads a register back and compares its defined bits.
    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, idx, $urandom(), rd);
        if ((rd & reg_mask(idx)) !== (want & reg_mask(idx))) begin
            $error("register %0d: expected %0h, got %0h", idx,
                   want & reg_mask(idx), rd & reg_mask(idx));
            fail_count++;
        end
    endtask

    // Writes a register with random upper bits, which the block must drop.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, ($urandom() & ~reg_mask(idx)) | (value & reg_mask(idx)), rd);
        case (idx)
            gscbr_pkg::RegShiftRow: begin
                shift_row_q = value[gscbr_pkg::ShiftW-1:0];
            end
            gscbr_pkg::RegShiftCol: begin
                shift_col_q = value[gscbr_pkg::ShiftW-1:0];
            end
            default: begin
                group_len_q = value[gscbr_pkg::LenW-1:0];
            end
        endcase
        check_reg(idx, value);
    endtask

    // ------------------------------------------------------------------------
    // Input stream
    // ------------------------------------------------------------------------

    // Offers one request and waits for it to be taken. tvalid stays high
    // afterwards; it is only lowered before a gap or when the stream drains.
    task automatic send_char(input logic [7:0] c, input logic msg_end);
        int gap;
        if (idle_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= msg_end;
        do @(posedge i_clk); while (!s_axis_tready);
        push_and_flush(c, msg_end);
    endtask

    task automatic send_text(input string s, input bit ends_msg);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], ends_msg && (i == s.len() - 1));
        end
    endtask

    // Mostly grid characters, so that the substitution is well exercised,
    // with a share of arbitrary codes.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(9) < 7) begin
            return grid_char($urandom_range(GridCells - 1));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_char(pick_char(), i == len - 1);
        end
    endtask

    // Stops offering, waits for every predicted character, then lets the
    // block settle so that the registers can be written safely.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_config(input int row, input int col, input int glen);
        wait_drained();
        write_reg(gscbr_pkg::RegShiftRow, row);
        write_reg(gscbr_pkg::RegShiftCol, col);
        write_reg(gscbr_pkg::RegGroupLen, glen);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: no shift and the whole message reversed. Covers both
    // ends of the grid and a range of codes just outside it, code 0 and 255.
    task automatic test_reset_defaults();
        check_reg(gscbr_pkg::RegShiftRow, 0);
        check_reg(gscbr_pkg::RegShiftCol, 0);
        check_reg(gscbr_pkg::RegGroupLen, 0);
        shift_row_q = '0;
        shift_col_q = '0;
        group_len_q = '0;
        send_text(" AZ19", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h30, 1'b0);    // '0' is not in the grid
        send_char(8'h40, 1'b0);    // just below 'A'
        send_char(8'h5B, 1'b0);    // just above 'Z'
        send_char(8'h3A, 1'b1);    // just above '9', ends the message
    endtask

    // Largest plain shift with single-character groups, then the wrapping
    // values 6 and 7 with groups of three: a full group in mid-message, a
    // partial group at its end, and a full group that ends the message.
    task automatic test_shift_extremes();
        set_config(5, 5, 1);
        send_char(ChA, 1'b0);
        send_char(Ch9, 1'b1);
        set_config(6, 7, 3);
        send_text("ABC", 1'b0);
        send_text("DE", 1'b1);
        send_text("XYZ", 1'b1);
    endtask

    // Random content under changing settings. The first message fills the
    // stack with a group length beyond the stack depth, so it flushes early
    // at 64 and again at the message end.
    task automatic test_random_messages();
        int sent;
        int glen;
        int cap;
        int len;
        set_config($urandom_range(7), $urandom_range(7),
                   $urandom_range(gscbr_pkg::MaxGroup + 1, 127));
        send_random_message(gscbr_pkg::MaxGroup + 1);
        sent = 0;
        while (sent < RandomItems) begin
            case ($urandom_range(4))
                0: glen = 1;
                1: glen = 2;
                2: glen = gscbr_pkg::MaxGroup;
                default: glen = $urandom_range(0, 12);
            endcase
            set_config($urandom_range(7), $urandom_range(7), glen);
            cap = (glen == 0 || glen >= 8) ? 12 : 2 * glen + 2;
            repeat ($urandom_range(1, 2)) begin
                len = $urandom_range(1, cap);
                send_random_message(len);
                sent += len;
            end
        end
    endtask

    // The output side stalls for a long stretch while requests keep coming,
    // so the block must fill up and refuse further input.
    task automatic test_output_stall();
        set_config($urandom_range(7), $urandom_range(7), 8);
        hold_request = 1'b1;
        send_random_message(16);
    endtask

    // No idling at all: back-to-back requests and a receiver always ready.
    task automatic test_full_rate();
        wait_drained();
        idle_on = 1'b0;
        set_config($urandom_range(7), $urandom_range(7), $urandom_range(1, 8));
        repeat (2) send_random_message($urandom_range(5, 10));
    endtask

    // ------------------------------------------------------------------------
    // Output stream: drives tready in bursts and checks each result.
    // ------------------------------------------------------------------------
    task automatic check_result();
        t_cipher_out want;
        if (pending_chars.size() == 0) begin
            $error("unexpected character %0h with no prediction waiting", m_axis_tdata);
            fail_count++;
            return;
        end
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
            $error("char_out: expected %0h, got %0h", want.ch, m_axis_tdata);
            fail_count++;
        end
        if (m_axis_tuser[0] !== want.not_in_grid) begin
            $error("not_in_grid: expected %0b, got %0b", want.not_in_grid, m_axis_tuser[0]);
            fail_count++;
        end
        if (m_axis_tuser[1] !== want.group_last) begin
            $error("group_last: expected %0b, got %0b", want.group_last, m_axis_tuser[1]);
            fail_count++;
        end
        if (m_axis_tlast !== want.msg_last) begin
            $error("msg_last: expected %0b, got %0b", want.msg_last, m_axis_tlast);
            fail_count++;
        end
    endtask

    // Values are sampled at the rising edge, before that edge's updates land,
    // so a handshake is seen exactly as the block saw it.
    initial begin
        int burst_left;
        bit ready_next;
        burst_left    = 0;
        ready_next    = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (hold_request) begin
                // The long stall is counted here, apart from the sender.
                hold_request = 1'b0;
                ready_next   = 1'b0;
                burst_left   = LongHoldCycles;
            end else if (burst_left > 0) begin
                burst_left--;
            end else if (idle_on && $urandom_range(3) == 0) begin
                ready_next = 1'b0;
                burst_left = $urandom_range(0, 18);
            end else begin
                ready_next = 1'b1;
                burst_left = idle_on ? $urandom_range(0, 18) : 0;
            end
            m_axis_tready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        fail_count    = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        shadow_depth  = 0;
        shift_row_q   = '0;
        shift_col_q   = '0;
        group_len_q   = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_shift_extremes();
        test_random_messages();
        test_output_stall();
        test_full_rate();

        wait_drained();
        if (fail_count == 0 && pending_chars.size() == 0) begin
            $display("grid_shift_cipher_block_reverse_core test passed");
        end else begin
            $display("grid_shift_cipher_block_reverse_core test failed");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #(TimeoutCycles * ClkPeriod);
        $display("grid_shift_cipher_block_reverse_core test failed");
        $finish;
    end

endmodule
